FILE: rtl/key_error_histogram_pareto_top_assert.svh
// Assertion macros for the key error histogram block.
// AST_IMP: same-cycle implication. AST_NXT: next-cycle implication.
`ifndef KEY_ERROR_HISTOGRAM_PARETO_TOP_ASSERT_SVH
`define KEY_ERROR_HISTOGRAM_PARETO_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define AST_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: label");
`define AST_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: label");
`else
`define AST_IMP(label, clk, rst, ante, cons)
`define AST_NXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/kehp_pkg.sv
// ----------------------------------------------------------------------------
// kehp_pkg
// Types, widths and codes shared by the key error histogram block.
// ----------------------------------------------------------------------------
package kehp_pkg;

  localparam int TABLE_DEPTH_DEF = 64;

  localparam int OPW   = 3;
  localparam int CHW   = 21;
  localparam int CNTW  = 32;
  localparam int TOTW  = 33;
  localparam int RATEW = 17;
  localparam int RANKW = 6;
  localparam int ERRW  = 38;
  localparam int PCTW  = 7;
  localparam int STW   = 3;
  localparam int FRACW = 16;

  localparam logic [PCTW-1:0] PCT_RESET = PCTW'(80);
  localparam logic [CNTW-1:0] CNT_MAX   = '1;

  localparam logic [OPW-1:0] OP_WRONG   = 3'd0;
  localparam logic [OPW-1:0] OP_CORRECT = 3'd1;
  localparam logic [OPW-1:0] OP_QUERY   = 3'd2;
  localparam logic [OPW-1:0] OP_PARETO  = 3'd3;
  localparam logic [OPW-1:0] OP_CLEAR   = 3'd4;

  localparam logic [STW-1:0] ST_UPDATED  = 3'd0;
  localparam logic [STW-1:0] ST_CREATED  = 3'd1;
  localparam logic [STW-1:0] ST_FULL     = 3'd2;
  localparam logic [STW-1:0] ST_FOUND    = 3'd3;
  localparam logic [STW-1:0] ST_NOTFOUND = 3'd4;
  localparam logic [STW-1:0] ST_PARETO   = 3'd5;
  localparam logic [STW-1:0] ST_EMPTY    = 3'd6;
  localparam logic [STW-1:0] ST_CLEARED  = 3'd7;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_CHK, S_HIT, S_MISS, S_PICK, S_STOP,
    S_DSTART, S_DWAIT, S_EMIT
  } state_t;

  typedef struct packed {
    logic            start;
    logic [CNTW-1:0] wrong;
    logic [TOTW-1:0] total;
  } div_req_t;

endpackage

FILE: rtl/kehp_if.sv
// ----------------------------------------------------------------------------
// kehp channel interfaces
// Request, response and configuration channels with valid/ready.
// ----------------------------------------------------------------------------
interface kehp_req_if;
  import kehp_pkg::*;
  logic           valid;
  logic           ready;
  logic [OPW-1:0] opcode;
  logic [CHW-1:0] char_code;
  modport source (output valid, opcode, char_code, input ready);
  modport sink (input valid, opcode, char_code, output ready);
endinterface

interface kehp_rsp_if;
  import kehp_pkg::*;
  logic             valid;
  logic             ready;
  logic [STW-1:0]   status;
  logic [CHW-1:0]   char_out;
  logic [CNTW-1:0]  wrong_cnt;
  logic [CNTW-1:0]  right_cnt;
  logic [TOTW-1:0]  attempt_sum;
  logic [RATEW-1:0] error_rate_q16;
  logic [RANKW-1:0] rank;
  logic [ERRW-1:0]  err_run;
  logic [ERRW-1:0]  err_total;
  logic             last;
  modport source (output valid, status, char_out, wrong_cnt, right_cnt,
                  attempt_sum, error_rate_q16, rank, err_run,
                  err_total, last, input ready);
  modport sink (input valid, status, char_out, wrong_cnt, right_cnt,
                attempt_sum, error_rate_q16, rank, err_run,
                err_total, last, output ready);
endinterface

interface kehp_cfg_if;
  import kehp_pkg::*;
  logic            valid;
  logic            ready;
  logic [PCTW-1:0] pareto_percent;
  modport source (output valid, pareto_percent, input ready);
  modport sink (input valid, pareto_percent, output ready);
endinterface

FILE: rtl/kehp_ram.sv
// ----------------------------------------------------------------------------
// kehp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kehp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/kehp_div.sv
// ----------------------------------------------------------------------------
// kehp_div
// Bit-serial divider for the Q1.16 error rate, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module kehp_div (
  input  logic                       clk,
  input  logic                       rst,
  input  kehp_pkg::div_req_t         req,
  output logic                       done,
  output logic [kehp_pkg::RATEW-1:0] quo
);
  import kehp_pkg::*;

  logic [TOTW-1:0] den;
  logic [TOTW-1:0] rem;
  logic [4:0]      cnt;
  logic            busy;
  logic [TOTW:0]   rem2;
  logic            ge;

  assign rem2 = {rem, 1'b0};
  assign ge   = rem2 >= {1'b0, den};
  assign done = busy && (cnt == 5'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (req.start) begin
      busy <= 1'b1;
      den  <= req.total;
      // wrong never exceeds the total, so the integer bit is set only on equality
      if (req.total == '0 || {1'b0, req.wrong} >= req.total) begin
        rem <= '0;
        quo <= (req.total == '0) ? '0 : {1'b1, {FRACW{1'b0}}};
        cnt <= 5'd0;
      end else begin
        rem <= {1'b0, req.wrong};
        quo <= '0;
        cnt <= 5'(FRACW);
      end
    end else if (busy && cnt != 5'd0) begin
      rem <= ge ? TOTW'(rem2 - {1'b0, den}) : rem2[TOTW-1:0];
      quo <= {quo[RATEW-2:0], ge};
      cnt <= cnt - 5'd1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end
endmodule

FILE: rtl/key_error_histogram_pareto_top.sv
// ----------------------------------------------------------------------------
// Key error histogram: table scan per entry (read, then check), then the bit-serial divider where a rate is needed.
// Pareto: error sum over all entries, then one scan per result; one request at a time.
// Synchronous reset empties the table and sets pareto_percent to 80.
// ----------------------------------------------------------------------------
module key_error_histogram_pareto_top #(
  parameter int TABLE_DEPTH = kehp_pkg::TABLE_DEPTH_DEF
) (
  input logic       clk,
  input logic       rst,
  kehp_req_if.sink  req_ch,
  kehp_rsp_if.source rsp_ch,
  kehp_cfg_if.sink  cfg
);
  import kehp_pkg::*;
  `include "key_error_histogram_pareto_top_assert.svh"

  localparam int AW = TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int RW = CHW + 2 * CNTW;
  localparam int MULW = ERRW + PCTW;

  state_t state, state_next;

  logic [PCTW-1:0] pct;
  logic [CW-1:0]   entry_count, idx, k;
  logic [OPW-1:0]  op;
  logic [CHW-1:0]  ch;
  logic            sel_phase;
  logic [AW-1:0]   hit_addr;
  logic [TABLE_DEPTH-1:0] picked;

  logic            bvalid;
  logic [AW-1:0]   bidx;
  logic [CHW-1:0]  bch;
  logic [CNTW-1:0] bw, bc;
  logic [ERRW-1:0] tot, cum;

  logic [STW-1:0]   res_status;
  logic [CHW-1:0]   res_char;
  logic [CNTW-1:0]  res_w, res_c;
  logic [RATEW-1:0] res_rate;
  logic             res_last;

  logic            we;
  logic [AW-1:0]   waddr;
  logic [RW-1:0]   wdata, rdata;
  logic [CHW-1:0]  rchar;
  logic [CNTW-1:0] rwr, rcr;
  logic            acc, last_idx, full, is_lookup, match, out_free, take;
  logic [CNTW-1:0] w_bump, c_bump;
  logic [MULW-1:0] lhs, rhs;
  logic            stop;

  div_req_t         div_req;
  logic             div_done;
  logic [RATEW-1:0] div_quo;

  kehp_ram #(.WIDTH(RW), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(idx[AW-1:0]), .rdata(rdata)
  );

  kehp_div u_div (.clk(clk), .rst(rst), .req(div_req), .done(div_done), .quo(div_quo));

  assign {rchar, rwr, rcr} = rdata;
  assign acc       = req_ch.valid && req_ch.ready;
  assign last_idx  = (idx + CW'(1)) == entry_count;
  assign full      = entry_count == CW'(TABLE_DEPTH);
  assign is_lookup = op != OP_PARETO;
  assign match     = rchar == ch;
  assign out_free  = !rsp_ch.valid || rsp_ch.ready;
  assign take      = !picked[idx[AW-1:0]] && (!bvalid || rwr > bw);
  assign w_bump    = (op == OP_WRONG && res_w != CNT_MAX) ? res_w + 32'd1 : res_w;
  assign c_bump    = (op == OP_CORRECT && res_c != CNT_MAX) ? res_c + 32'd1 : res_c;
  assign lhs       = MULW'(cum) * MULW'(100);
  assign rhs       = MULW'(pct) * MULW'(tot);
  assign stop      = (tot != '0 && lhs >= rhs) || ((k + CW'(1)) == entry_count);

  assign cfg.ready = 1'b1;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (acc) begin
          case (req_ch.opcode)
            OP_WRONG, OP_CORRECT, OP_QUERY:
              state_next = (entry_count == '0) ? S_MISS : S_RD;
            OP_PARETO: state_next = (entry_count == '0) ? S_EMIT : S_RD;
            OP_CLEAR:  state_next = S_EMIT;
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_RD: state_next = S_CHK;
      S_CHK: begin
        if (is_lookup) begin
          state_next = match ? S_HIT : (last_idx ? S_MISS : S_RD);
        end else begin
          state_next = (sel_phase && last_idx) ? S_PICK : S_RD;
        end
      end
      S_HIT:    state_next = S_DSTART;
      S_MISS:   state_next = (op == OP_QUERY || full) ? S_EMIT : S_DSTART;
      S_PICK:   state_next = S_STOP;
      S_STOP:   state_next = S_DSTART;
      S_DSTART: state_next = S_DWAIT;
      S_DWAIT:  state_next = div_done ? S_EMIT : S_DWAIT;
      S_EMIT: begin
        if (out_free) begin
          state_next = (op == OP_PARETO && !res_last) ? S_RD : S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs to RAM, divider and request channel
  always_comb begin
    we            = 1'b0;
    waddr         = hit_addr;
    wdata         = {ch, w_bump, c_bump};
    req_ch.ready  = state == S_IDLE;
    div_req.start = state == S_DSTART;
    div_req.wrong = res_w;
    div_req.total = TOTW'(res_w) + TOTW'(res_c);
    case (state)
      S_HIT: we = op != OP_QUERY;
      S_MISS: begin
        we    = op != OP_QUERY && !full;
        waddr = entry_count[AW-1:0];
        wdata = {ch, 31'd0, op == OP_WRONG, 31'd0, op == OP_CORRECT};
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      pct         <= PCT_RESET;
      entry_count <= '0;
      picked      <= '0;
      rsp_ch.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid) begin
        pct <= cfg.pareto_percent;
      end
      if (state == S_EMIT && out_free) begin
        rsp_ch.valid <= 1'b1;
      end else if (rsp_ch.ready) begin
        rsp_ch.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (acc) begin
            op         <= req_ch.opcode;
            ch         <= req_ch.char_code;
            idx        <= '0;
            k          <= '0;
            sel_phase  <= 1'b0;
            bvalid     <= 1'b0;
            tot        <= '0;
            cum        <= '0;
            res_w      <= '0;
            res_c      <= '0;
            res_rate   <= '0;
            res_last   <= 1'b1;
            res_char   <= (req_ch.opcode == OP_CLEAR || req_ch.opcode == OP_PARETO) ?
                          '0 : req_ch.char_code;
            res_status <= (req_ch.opcode == OP_CLEAR)  ? ST_CLEARED :
                          (req_ch.opcode == OP_PARETO) ? ST_EMPTY : ST_NOTFOUND;
            if (req_ch.opcode == OP_CLEAR) begin
              entry_count <= '0;
            end
            if (req_ch.opcode == OP_PARETO) begin
              picked <= '0;
            end
          end
        end
        S_CHK: begin
          if (is_lookup) begin
            idx <= idx + CW'(1);
            if (match) begin
              hit_addr <= idx[AW-1:0];
              res_w    <= rwr;
              res_c    <= rcr;
            end
          end else if (!sel_phase) begin
            tot <= tot + ERRW'(rwr);
            if (last_idx) begin
              idx       <= '0;
              sel_phase <= 1'b1;
            end else begin
              idx <= idx + CW'(1);
            end
          end else begin
            idx <= idx + CW'(1);
            if (take) begin
              bvalid <= 1'b1;
              bidx   <= idx[AW-1:0];
              bch    <= rchar;
              bw     <= rwr;
              bc     <= rcr;
            end
          end
        end
        S_HIT: begin
          res_status <= (op == OP_QUERY) ? ST_FOUND : ST_UPDATED;
          res_w      <= w_bump;
          res_c      <= c_bump;
        end
        S_MISS: begin
          if (op == OP_QUERY) begin
            res_status <= ST_NOTFOUND;
          end else if (full) begin
            res_status <= ST_FULL;
          end else begin
            res_status  <= ST_CREATED;
            res_w       <= {31'd0, op == OP_WRONG};
            res_c       <= {31'd0, op == OP_CORRECT};
            entry_count <= entry_count + CW'(1);
          end
        end
        S_PICK: begin
          picked[bidx] <= 1'b1;
          cum          <= cum + ERRW'(bw);
          res_status   <= ST_PARETO;
          res_char     <= bch;
          res_w        <= bw;
          res_c        <= bc;
        end
        S_STOP: res_last <= stop;
        S_DWAIT: begin
          if (div_done) begin
            res_rate <= div_quo;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            rsp_ch.status         <= res_status;
            rsp_ch.char_out       <= res_char;
            rsp_ch.wrong_cnt      <= res_w;
            rsp_ch.right_cnt      <= res_c;
            rsp_ch.attempt_sum    <= TOTW'(res_w) + TOTW'(res_c);
            rsp_ch.error_rate_q16 <= res_rate;
            rsp_ch.rank           <= (res_status == ST_PARETO) ? RANKW'(k) : '0;
            rsp_ch.err_run        <= (res_status == ST_PARETO) ? cum : '0;
            rsp_ch.err_total      <= (res_status == ST_PARETO) ? tot : '0;
            rsp_ch.last           <= res_last;
            // advance to the next pareto pick
            if (op == OP_PARETO && !res_last) begin
              k      <= k + CW'(1);
              idx    <= '0;
              bvalid <= 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  `AST_IMP(a_count_bound, clk, rst, 1'b1, entry_count <= CW'(TABLE_DEPTH))
  `AST_IMP(a_div_done_wait, clk, rst, div_done, state == S_DWAIT)
  `AST_IMP(a_write_state, clk, rst, we, state == S_HIT || state == S_MISS)
  `AST_NXT(a_emit_loads, clk, rst, state == S_EMIT && out_free, rsp_ch.valid)

endmodule
